@@ hw/rtl/lhtt_pkg.sv @@
// ----------------------------------------------------------------------------
// lhtt_pkg
// Shared types and constants of the lock holder tag table.
// ----------------------------------------------------------------------------
package lhtt_pkg;

    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned CPU_W      = 8;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned IBITS_W    = 4;

    localparam logic [ADDR_W-1:0]  HASH_MULT      = 64'h61C8864680B583EB;
    localparam logic [IBITS_W-1:0] IBITS_RESET    = 4'd10;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_TABLE  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_COLLISION = 3'd3,
        ST_SKIPPED   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_BITS  = 2'd0,
        CFG_TABLE_READY = 2'd1
    } t_cfg_idx;

    // operand pair fed to the shared 32x32 multiplier
    typedef enum logic [1:0] {
        MUL_LO_LO = 2'd0,
        MUL_HI_LO = 2'd1,
        MUL_LO_HI = 2'd2
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD_HI = 2'd2
    } t_acc_op;

    typedef struct packed {
        logic     latch;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     clr_step;
        logic     rd_en;
        logic     eval;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_status;

endpackage

@@ hw/rtl/lhtt_ram.sv @@
// ----------------------------------------------------------------------------
// lhtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhtt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lhtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// lhtt_ctrl
// Sequencer: clearing sweep after reset, then hash, read and update per item.
// ----------------------------------------------------------------------------
module lhtt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lhtt_pkg::t_dp_status i_dp_status,
    output lhtt_pkg::t_dp_cmd   o_dp_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL0  = 8'b0000_0100,
        S_MUL1  = 8'b0000_1000,
        S_MUL2  = 8'b0001_0000,
        S_ADD   = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_EVAL  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state          = r_state;
        o_dp_cmd         = '0;
        o_dp_cmd.mul_sel = lhtt_pkg::MUL_LO_LO;
        o_dp_cmd.acc_op  = lhtt_pkg::ACC_HOLD;
        case (r_state)
            S_CLEAR: begin
                o_dp_cmd.clr_step = 1'b1;
                if (i_dp_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.latch = 1'b1;
                    n_state        = S_MUL0;
                end
            end
            S_MUL0: begin
                o_dp_cmd.mul_sel = lhtt_pkg::MUL_LO_LO;
                n_state          = S_MUL1;
            end
            S_MUL1: begin
                o_dp_cmd.mul_sel = lhtt_pkg::MUL_HI_LO;
                o_dp_cmd.acc_op  = lhtt_pkg::ACC_LOAD;
                n_state          = S_MUL2;
            end
            S_MUL2: begin
                o_dp_cmd.mul_sel = lhtt_pkg::MUL_LO_HI;
                o_dp_cmd.acc_op  = lhtt_pkg::ACC_ADD_HI;
                n_state          = S_ADD;
            end
            S_ADD: begin
                o_dp_cmd.acc_op = lhtt_pkg::ACC_ADD_HI;
                n_state         = S_READ;
            end
            S_READ: begin
                o_dp_cmd.rd_en = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_dp_cmd.eval = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_valid = (r_state == S_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

@@ hw/rtl/lhtt_dp.sv @@
// ----------------------------------------------------------------------------
// lhtt_dp
// Datapath: config registers, multiplicative hash, slot table and counters.
// ----------------------------------------------------------------------------
module lhtt_dp #(
    parameter int unsigned SLOT_INDEX_BITS = 10,
    parameter int unsigned CPU_ID_BITS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lhtt_pkg::t_dp_cmd                 i_dp_cmd,
    output lhtt_pkg::t_dp_status              o_dp_status,
    input  logic                              i_cfg_we,
    input  logic [lhtt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lhtt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                        i_command,
    input  logic [lhtt_pkg::ADDR_W-1:0]       i_lock_address,
    input  logic [lhtt_pkg::CPU_W-1:0]        i_cpu_id,
    output logic [2:0]                        o_status,
    output logic [lhtt_pkg::CPU_W-1:0]        o_holder_cpu,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_stamp_count,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_clear_count,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_empty_count,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_collision_count
);

    localparam int unsigned SLOTS   = 2 ** SLOT_INDEX_BITS;
    localparam int unsigned HOLD_W  = CPU_ID_BITS + 1;
    localparam int unsigned ENTRY_W = lhtt_pkg::ADDR_W + HOLD_W;
    localparam int unsigned HALF_W  = lhtt_pkg::ADDR_W / 2;
    localparam logic [4:0]  SIB     = 5'(SLOT_INDEX_BITS);

    localparam logic [HALF_W-1:0] K_LO = lhtt_pkg::HASH_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] K_HI = lhtt_pkg::HASH_MULT[lhtt_pkg::ADDR_W-1:HALF_W];

    // configuration
    logic [lhtt_pkg::IBITS_W-1:0] r_index_bits;
    logic                         r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= lhtt_pkg::IBITS_RESET;
            r_ready      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lhtt_pkg::CFG_INDEX_BITS:  r_index_bits <= i_cfg_data[lhtt_pkg::IBITS_W-1:0];
                lhtt_pkg::CFG_TABLE_READY: r_ready      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item capture
    lhtt_pkg::t_cmd              r_cmd;
    logic [lhtt_pkg::ADDR_W-1:0] r_addr;
    logic [lhtt_pkg::CPU_W-1:0]  r_cpu;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.latch) begin
            r_cmd  <= lhtt_pkg::t_cmd'(i_command);
            r_addr <= i_lock_address;
            r_cpu  <= i_cpu_id;
        end
    end

    // hash: low 64 bits of addr * K from three 32x32 partial products
    logic [HALF_W-1:0]           mul_a, mul_b;
    logic [lhtt_pkg::ADDR_W-1:0] r_prod;
    logic [lhtt_pkg::ADDR_W-1:0] r_hash;

    always_comb begin
        mul_a = r_addr[HALF_W-1:0];
        mul_b = K_LO;
        case (i_dp_cmd.mul_sel)
            lhtt_pkg::MUL_LO_LO: begin
                mul_a = r_addr[HALF_W-1:0];
                mul_b = K_LO;
            end
            lhtt_pkg::MUL_HI_LO: begin
                mul_a = r_addr[lhtt_pkg::ADDR_W-1:HALF_W];
                mul_b = K_LO;
            end
            lhtt_pkg::MUL_LO_HI: begin
                mul_a = r_addr[HALF_W-1:0];
                mul_b = K_HI;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_dp_cmd.acc_op)
            lhtt_pkg::ACC_LOAD:   r_hash <= r_prod;
            lhtt_pkg::ACC_ADD_HI: r_hash[lhtt_pkg::ADDR_W-1:HALF_W] <=
                r_hash[lhtt_pkg::ADDR_W-1:HALF_W] + r_prod[HALF_W-1:0];
            default: ;
        endcase
    end

    // slot index: top bits of the hash, width saturated to 1..SLOT_INDEX_BITS
    logic [4:0]                 ib_ext, ib_sat, shamt;
    logic [SLOT_INDEX_BITS-1:0] hash_top, rd_index;
    logic [SLOT_INDEX_BITS-1:0] r_index;

    always_comb begin
        ib_ext = {1'b0, r_index_bits};
        if (ib_ext == 5'd0) begin
            ib_sat = 5'd1;
        end else if (ib_ext > SIB) begin
            ib_sat = SIB;
        end else begin
            ib_sat = ib_ext;
        end
        shamt    = SIB - ib_sat;
        hash_top = r_hash[lhtt_pkg::ADDR_W-1 -: SLOT_INDEX_BITS];
        rd_index = hash_top >> shamt;
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd_en) begin
            r_index <= rd_index;
        end
    end

    // clearing sweep address
    logic [SLOT_INDEX_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_dp_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_dp_status.clr_last = &r_clr_addr;

    // slot table: {tag, cpu+1}
    logic [ENTRY_W-1:0]          rd_data;
    logic [lhtt_pkg::ADDR_W-1:0] slot_tag;
    logic [HOLD_W-1:0]           slot_hold;
    logic                        match;

    assign slot_tag  = rd_data[ENTRY_W-1:HOLD_W];
    assign slot_hold = rd_data[HOLD_W-1:0];
    assign match     = (slot_hold != '0) && (slot_tag == r_addr);

    // cpu masked to CPU_ID_BITS, and stored holder back to the 8-bit field
    logic [CPU_ID_BITS+lhtt_pkg::CPU_W-1:0] cpu_ext;
    logic [CPU_ID_BITS-1:0]                 cpu_m;
    logic [HOLD_W-1:0]                      cpu_plus1;
    logic [HOLD_W-1:0]                      hold_m1;
    logic [HOLD_W+lhtt_pkg::CPU_W-1:0]      hold_ext;

    assign cpu_ext   = {{CPU_ID_BITS{1'b0}}, r_cpu};
    assign cpu_m     = cpu_ext[CPU_ID_BITS-1:0];
    assign cpu_plus1 = {1'b0, cpu_m} + 1'b1;
    assign hold_m1   = slot_hold - 1'b1;
    assign hold_ext  = {{lhtt_pkg::CPU_W{1'b0}}, hold_m1};

    lhtt_pkg::t_status          n_status;
    logic [lhtt_pkg::CPU_W-1:0] n_holder;
    logic                       upd_we;
    logic [ENTRY_W-1:0]         upd_data;
    logic                       inc_stamp, inc_clear, inc_empty, inc_coll;

    always_comb begin
        n_status  = lhtt_pkg::ST_OK;
        n_holder  = '0;
        upd_we    = 1'b0;
        upd_data  = '0;
        inc_stamp = 1'b0;
        inc_clear = 1'b0;
        inc_empty = 1'b0;
        inc_coll  = 1'b0;
        if (r_cmd != lhtt_pkg::CMD_NONE) begin
            if (!r_ready) begin
                n_status = lhtt_pkg::ST_NO_TABLE;
            end else begin
                case (r_cmd)
                    lhtt_pkg::CMD_SET: begin
                        upd_we    = 1'b1;
                        upd_data  = {r_addr, cpu_plus1};
                        inc_stamp = 1'b1;
                    end
                    lhtt_pkg::CMD_CLEAR: begin
                        if (match) begin
                            upd_we    = 1'b1;
                            inc_clear = 1'b1;
                        end else begin
                            n_status = lhtt_pkg::ST_SKIPPED;
                        end
                    end
                    lhtt_pkg::CMD_QUERY: begin
                        if (slot_hold == '0) begin
                            n_status  = lhtt_pkg::ST_EMPTY;
                            inc_empty = 1'b1;
                        end else if (!match) begin
                            n_status = lhtt_pkg::ST_COLLISION;
                            inc_coll = 1'b1;
                        end else begin
                            n_holder = hold_ext[lhtt_pkg::CPU_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    logic                       ram_we;
    logic [SLOT_INDEX_BITS-1:0] ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;

    assign ram_we    = i_dp_cmd.clr_step || (i_dp_cmd.eval && upd_we);
    assign ram_waddr = i_dp_cmd.clr_step ? r_clr_addr : r_index;
    assign ram_wdata = i_dp_cmd.clr_step ? '0 : upd_data;

    lhtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_dp_cmd.rd_en),
        .i_raddr (rd_index),
        .o_rdata (rd_data)
    );

    // result and counters
    lhtt_pkg::t_status           r_status;
    logic [lhtt_pkg::CPU_W-1:0]  r_holder;
    logic [lhtt_pkg::COUNT_W-1:0] r_stamps, r_clears, r_empties, r_colls;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.eval) begin
            r_status <= n_status;
            r_holder <= n_holder;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamps  <= '0;
            r_clears  <= '0;
            r_empties <= '0;
            r_colls   <= '0;
        end else if (i_dp_cmd.eval) begin
            if (inc_stamp) r_stamps  <= r_stamps + 1'b1;
            if (inc_clear) r_clears  <= r_clears + 1'b1;
            if (inc_empty) r_empties <= r_empties + 1'b1;
            if (inc_coll)  r_colls   <= r_colls + 1'b1;
        end
    end

    assign o_status          = r_status;
    assign o_holder_cpu      = r_holder;
    assign o_stamp_count     = r_stamps;
    assign o_clear_count     = r_clears;
    assign o_empty_count     = r_empties;
    assign o_collision_count = r_colls;

endmodule

@@ hw/rtl/lock_holder_tag_table_top.sv @@
// ----------------------------------------------------------------------------
// lock_holder_tag_table_top
// Direct-mapped table recording which CPU holds a lock, keyed by a
// multiplicative hash of the lock address.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**SLOT_INDEX_BITS slots (1024 by default)
// of the slot table to empty, one slot per cycle, with busy high; config
// writes are taken during that time. An item is taken when start is high and
// busy is low. Its result shows on the o_ ports with o_valid high for exactly
// one cycle; the receiver cannot stall it. busy drops in that same cycle, and
// no new item is taken before then. Each item makes three passes through the
// shared 32x32 multiplier, one add, one registered read of the one-write,
// one-read slot table and one update. Count outputs always show the running
// totals and are valid with the result.
// ----------------------------------------------------------------------------
module lock_holder_tag_table_top #(
    parameter int unsigned SLOT_INDEX_BITS = 10,
    parameter int unsigned CPU_ID_BITS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [lhtt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lhtt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                        i_command,
    input  logic [lhtt_pkg::ADDR_W-1:0]       i_lock_address,
    input  logic [lhtt_pkg::CPU_W-1:0]        i_cpu_id,
    output logic                              o_valid,
    output logic [2:0]                        o_status,
    output logic [lhtt_pkg::CPU_W-1:0]        o_holder_cpu,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_stamp_count,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_clear_count,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_empty_count,
    output logic [lhtt_pkg::COUNT_W-1:0]      o_collision_count
);

    lhtt_pkg::t_dp_cmd    dp_cmd;
    lhtt_pkg::t_dp_status dp_status;

    lhtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd),
        .o_busy      (busy),
        .o_valid     (o_valid)
    );

    lhtt_dp #(
        .SLOT_INDEX_BITS (SLOT_INDEX_BITS),
        .CPU_ID_BITS     (CPU_ID_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_dp_status       (dp_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_lock_address    (i_lock_address),
        .i_cpu_id          (i_cpu_id),
        .o_status          (o_status),
        .o_holder_cpu      (o_holder_cpu),
        .o_stamp_count     (o_stamp_count),
        .o_clear_count     (o_clear_count),
        .o_empty_count     (o_empty_count),
        .o_collision_count (o_collision_count)
    );

endmodule

@@ hw/rtl/lhtt_checker.sv @@
// ----------------------------------------------------------------------------
// lhtt_checker
// Port-level checks of the lock holder tag table, bound to the top level.
// ----------------------------------------------------------------------------
module lhtt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [2:0]                   o_status,
    input logic [lhtt_pkg::CPU_W-1:0]   o_holder_cpu,
    input logic [lhtt_pkg::COUNT_W-1:0] o_stamp_count
);

    // an accepted item yields its result after a fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("result missing 7 cycles after accept");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_holder_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != lhtt_pkg::ST_OK)) |-> (o_holder_cpu == '0))
        else $error("holder reported on a result that found nothing");

    a_no_table_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == lhtt_pkg::ST_NO_TABLE)) |-> $stable(o_stamp_count))
        else $error("set counter moved without a table");

endmodule

bind lock_holder_tag_table_top lhtt_checker u_lhtt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_holder_cpu  (o_holder_cpu),
    .o_stamp_count (o_stamp_count)
);
